// File: rtl/core/sbmc_pkg.sv
// Shared types and constants for the system bus memory and console block.
package sbmc_pkg;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_BAD  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ALIGN = 2'd2;
  localparam logic [1:0] ST_SIZE  = 2'd3;

  localparam logic [1:0] CK_CHAR = 2'd0;
  localparam logic [1:0] CK_DEC  = 2'd1;
  localparam logic [1:0] CK_HEX  = 2'd2;

  localparam logic CFG_RAM_BASE = 1'b0;
  localparam logic CFG_CON_BASE = 1'b1;

  localparam logic [31:0] RAM_BASE_RST = 32'h8000_0000;
  localparam logic [31:0] CON_BASE_RST = 32'h1000_0000;

  localparam logic [31:0] CON_SPAN     = 32'd12;
  localparam logic [31:0] CON_OFF_CHAR = 32'd0;
  localparam logic [31:0] CON_OFF_DEC  = 32'd4;
  localparam logic [31:0] CON_OFF_HEX  = 32'd8;

  typedef struct packed {
    logic load;
    logic decode;
    logic check;
    logic finish;
  } sbmc_cmd_t;

endpackage

// File: rtl/core/sbmc_ram.sv
// Generic single-port RAM with registered read.
module sbmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/sbmc_ctrl.sv
// Sequencer for one bus word: load, decode, check/access, result.
module sbmc_ctrl import sbmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output sbmc_cmd_t cmd,
  output logic      out_valid
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_CHK  = 2'd2;
  localparam logic [1:0] S_MEM  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        cmd.check = 1'b1;
        state_nxt = S_MEM;
      end
      S_MEM: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/sbmc_dp.sv
// Datapath: config registers, address decode, checks, byte-lane RAM and result registers.
module sbmc_dp import sbmc_pkg::*; #(
  parameter int RAM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  sbmc_cmd_t   cmd,
  input  logic        in_command,
  input  logic [1:0]  in_access_size,
  input  logic [31:0] in_address,
  input  logic [31:0] in_write_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic [31:0] out_read_data,
  output logic [1:0]  out_status,
  output logic        out_console_valid,
  output logic [1:0]  out_console_kind,
  output logic [31:0] out_console_value
);

  localparam int RAM_WORDS = (RAM_BYTES + 3) / 4;
  localparam int RAM_AW = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
  localparam logic [32:0] RAM_LIM = 33'(RAM_BYTES);

  logic [31:0] ram_base_r, con_base_r;
  logic        cmd_r;
  logic [1:0]  size_r;
  logic [31:0] addr_r, wdata_r, coff_r, roff_r;
  logic        rd_go_r;
  logic [1:0]  status_r, ckind_r;
  logic        cvld_r;
  logic [31:0] cval_r;
  logic [31:0] o_rdata_r, o_cval_r;
  logic [1:0]  o_status_r, o_ckind_r;
  logic        o_cvld_r;

  logic        con_hit, ram_hit, misalign, end_over, ram_go;
  logic [2:0]  nbytes;
  logic [1:0]  status_nxt, ckind_nxt;
  logic        cvld_nxt;
  logic [31:0] cval_nxt, rdata_nxt;
  logic [1:0]  sel;
  logic [7:0]  lane_q [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_base_r <= RAM_BASE_RST;
      con_base_r <= CON_BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RAM_BASE: ram_base_r <= cfg_data;
        CFG_CON_BASE: con_base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_command;
      size_r  <= in_access_size;
      addr_r  <= in_address;
      wdata_r <= in_write_data;
    end
    if (cmd.decode) begin
      coff_r <= addr_r - con_base_r;
      roff_r <= addr_r - ram_base_r;
    end
    if (cmd.check) begin
      rd_go_r  <= ram_go && (cmd_r == CMD_READ);
      status_r <= status_nxt;
      cvld_r   <= cvld_nxt;
      ckind_r  <= ckind_nxt;
      cval_r   <= cval_nxt;
    end
    if (cmd.finish) begin
      o_rdata_r  <= rdata_nxt;
      o_status_r <= status_r;
      o_cvld_r   <= cvld_r;
      o_ckind_r  <= ckind_r;
      o_cval_r   <= cval_r;
    end
  end

  always_comb begin
    unique case (size_r)
      SZ_BYTE: nbytes = 3'd1;
      SZ_HALF: nbytes = 3'd2;
      SZ_WORD: nbytes = 3'd4;
      SZ_BAD:  nbytes = 3'd0;
      default: nbytes = 3'd0;
    endcase
  end

  always_comb begin
    con_hit    = coff_r < CON_SPAN;
    ram_hit    = {1'b0, roff_r} < RAM_LIM;
    misalign   = |(addr_r[1:0] & (nbytes[1:0] - 2'd1));
    end_over   = ({1'b0, roff_r} + 33'(nbytes)) > RAM_LIM;
    status_nxt = ST_OK;
    cvld_nxt   = 1'b0;
    ckind_nxt  = CK_CHAR;
    cval_nxt   = '0;
    ram_go     = 1'b0;
    priority if (con_hit) begin
      if (cmd_r == CMD_WRITE) begin
        priority if (coff_r == CON_OFF_CHAR) begin
          cvld_nxt = 1'b1;
          cval_nxt = {24'd0, wdata_r[7:0]};
        end else if (coff_r == CON_OFF_DEC) begin
          cvld_nxt  = 1'b1;
          ckind_nxt = CK_DEC;
          cval_nxt  = wdata_r;
        end else if (coff_r == CON_OFF_HEX) begin
          cvld_nxt  = 1'b1;
          ckind_nxt = CK_HEX;
          cval_nxt  = wdata_r;
        end else begin
          cvld_nxt = 1'b0;
        end
      end
    end else if (!ram_hit) begin
      status_nxt = ST_RANGE;
    end else if (size_r == SZ_BAD) begin
      status_nxt = ST_SIZE;
    end else if (misalign) begin
      status_nxt = ST_ALIGN;
    end else if (end_over) begin
      status_nxt = ST_RANGE;
    end else begin
      ram_go = 1'b1;
    end
  end

  // lane k holds bytes whose RAM offset is k mod 4; an access may span two words
  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [1:0]        idx;
    logic              act;
    logic              we;
    logic [RAM_AW-1:0] la;
    logic [7:0]        wb;

    assign idx = 2'(k) - roff_r[1:0];
    assign act = {1'b0, idx} < nbytes;
    assign we  = cmd.check && ram_go && act && (cmd_r == CMD_WRITE);
    assign la  = roff_r[2 +: RAM_AW] + RAM_AW'(2'(k) < roff_r[1:0]);
    assign wb  = 8'(wdata_r >> {idx, 3'b000});

    sbmc_ram #(
      .WIDTH(8),
      .DEPTH(RAM_WORDS)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .addr  (la),
      .wdata (wb),
      .rdata (lane_q[k])
    );
  end

  always_comb begin
    rdata_nxt = '0;
    sel       = '0;
    for (int i = 0; i < 4; i++) begin
      sel = 2'(i) + roff_r[1:0];
      if (rd_go_r && (3'(i) < nbytes)) begin
        rdata_nxt[8*i +: 8] = lane_q[sel];
      end
    end
  end

  assign out_read_data     = o_rdata_r;
  assign out_status        = o_status_r;
  assign out_console_valid = o_cvld_r;
  assign out_console_kind  = o_ckind_r;
  assign out_console_value = o_cval_r;

endmodule

// File: rtl/core/system_bus_memory_console.sv
// Bus slave with RAM and console output window.
//
// Input: raise start with in_command, in_access_size, in_address and
// in_write_data; the word is taken at a clock edge where start is high and
// busy is low. busy stays high from that edge until the result shows.
// Result: out_valid is high for exactly one cycle, with read data, status and
// console output; the receiver must take it.
// A new word can be accepted in the result cycle, but not while busy is high.
// The steps, in order, are decode (window offsets), check plus RAM access, RAM
// read data into the result registers, and the result cycle.
// Config: cfg_valid/cfg_index/cfg_data; cfg_ready is always high. Index 0 is
// the RAM base, index 1 the console base. Write only while idle.
// Reset (rst_n low, synchronous) restores both bases and idles the sequencer.
// RAM contents are not cleared: a read of an unwritten byte is undefined.
module system_bus_memory_console import sbmc_pkg::*; #(
  parameter int RAM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [1:0]  in_access_size,
  input  logic [31:0] in_address,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  output logic [31:0] out_read_data,
  output logic [1:0]  out_status,
  output logic        out_console_valid,
  output logic [1:0]  out_console_kind,
  output logic [31:0] out_console_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  sbmc_cmd_t cmd;

  assign cfg_ready = 1'b1;

  sbmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  sbmc_dp #(
    .RAM_BYTES(RAM_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_command        (in_command),
    .in_access_size    (in_access_size),
    .in_address        (in_address),
    .in_write_data     (in_write_data),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_read_data     (out_read_data),
    .out_status        (out_status),
    .out_console_valid (out_console_valid),
    .out_console_kind  (out_console_kind),
    .out_console_value (out_console_value)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("result strobe missing after accept");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_console_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_console_valid) |-> (out_status == ST_OK && out_read_data == '0))
    else $error("console output with error status or read data");
`endif

endmodule

// File: bench/tb_system_bus_memory_console.sv
// Self-checking testbench for the system bus memory and console block.
`timescale 1ns / 100ps

module tb_system_bus_memory_console import sbmc_pkg::*;;

  localparam int RAM_BYTES = 65536;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  size;
    logic [31:0] addr;
    logic [31:0] data;
    logic        hold;
  } bus_word_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [1:0]  status;
    logic        cvalid;
    logic [1:0]  ckind;
    logic [31:0] cvalue;
  } bus_reply_t;

  typedef struct packed {
    logic        console;
    logic [31:0] con_off;
    logic [31:0] ram_off;
    logic [1:0]  status;
  } route_t;

  typedef struct {
    int unsigned off;
    logic [1:0]  size;
  } byte_span_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_command = CMD_READ;
  logic [1:0]  in_access_size = SZ_BYTE;
  logic [31:0] in_address = 32'd0;
  logic [31:0] in_write_data = 32'd0;
  logic        out_valid;
  logic [31:0] out_read_data;
  logic [1:0]  out_status;
  logic        out_console_valid;
  logic [1:0]  out_console_kind;
  logic [31:0] out_console_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_RAM_BASE;
  logic [31:0] cfg_data = 32'd0;

  logic [31:0] cfg_ram_base = RAM_BASE_RST;
  logic [31:0] cfg_con_base = CON_BASE_RST;
  logic [7:0]  ram_image [RAM_BYTES];
  bit          ram_filled [RAM_BYTES];
  byte_span_t  stored_spans [$];
  bus_word_t   pending_words [$];
  bus_reply_t  expected_replies [$];
  bus_word_t   active_word;
  int          sender_idle_pct = 0;
  int          mismatches = 0;

  system_bus_memory_console #(.RAM_BYTES(RAM_BYTES)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_access_size(in_access_size),
    .in_address(in_address), .in_write_data(in_write_data),
    .out_valid(out_valid), .out_read_data(out_read_data), .out_status(out_status),
    .out_console_valid(out_console_valid), .out_console_kind(out_console_kind),
    .out_console_value(out_console_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic route_t route_word(bus_word_t w);
    route_t     r;
    logic [32:0] nb;
    r.con_off = w.addr - cfg_con_base;
    r.ram_off = w.addr - cfg_ram_base;
    r.console = (r.con_off < CON_SPAN);
    r.status  = ST_OK;
    nb = 33'd1 << w.size;
    if (!r.console) begin
      if (r.ram_off >= RAM_BYTES) r.status = ST_RANGE;
      else if (w.size == SZ_BAD) r.status = ST_SIZE;
      else if ((w.addr & (nb[31:0] - 32'd1)) != 32'd0) r.status = ST_ALIGN;
      else if ({1'b0, r.ram_off} + nb > 33'(RAM_BYTES)) r.status = ST_RANGE;
    end
    return r;
  endfunction

  // Applies one bus word to the RAM image and returns the reply it should give.
  function automatic bus_reply_t bus_access_reply(bus_word_t w);
    route_t      r;
    bus_reply_t  e;
    int unsigned idx;
    r = route_word(w);
    e = '0;
    e.status = r.status;
    if (r.console && w.cmd == CMD_WRITE) begin
      case (r.con_off)
        CON_OFF_CHAR: begin
          e.cvalid = 1'b1;
          e.ckind  = CK_CHAR;
          e.cvalue = {24'd0, w.data[7:0]};
        end
        CON_OFF_DEC: begin
          e.cvalid = 1'b1;
          e.ckind  = CK_DEC;
          e.cvalue = w.data;
        end
        CON_OFF_HEX: begin
          e.cvalid = 1'b1;
          e.ckind  = CK_HEX;
          e.cvalue = w.data;
        end
        default: ;
      endcase
    end else if (!r.console && r.status == ST_OK) begin
      for (int i = 0; i < (1 << w.size); i++) begin
        idx = r.ram_off + i;
        if (w.cmd == CMD_WRITE) ram_image[idx] = w.data[8*i +: 8];
        else e.rdata[8*i +: 8] = ram_image[idx];
      end
    end
    return e;
  endfunction

  // Queues a word; a RAM read that would touch unwritten bytes becomes a write.
  function automatic void post_word(bus_word_t w);
    route_t r;
    bit     covered;
    r = route_word(w);
    if (!r.console && r.status == ST_OK) begin
      covered = 1'b1;
      for (int i = 0; i < (1 << w.size); i++)
        if (!ram_filled[r.ram_off + i]) covered = 1'b0;
      if (!covered) w.cmd = CMD_WRITE;
      if (w.cmd == CMD_WRITE) begin
        for (int i = 0; i < (1 << w.size); i++) ram_filled[r.ram_off + i] = 1'b1;
        stored_spans.push_back('{r.ram_off, w.size});
      end
    end
    pending_words.push_back(w);
  endfunction

  function automatic bus_word_t bus_word(logic cmd, logic [1:0] size, logic [31:0] addr,
                                         logic [31:0] data);
    bus_word_t w;
    w = '0;
    w.cmd  = cmd;
    w.size = size;
    w.addr = addr;
    w.data = data;
    return w;
  endfunction

  function automatic bus_word_t random_word();
    bus_word_t   w;
    byte_span_t  sp;
    int unsigned pick;
    logic [31:0] off, nb, a;
    logic [1:0]  s;
    bit          found;
    w = '0;
    w.cmd  = 1'($urandom_range(0, 1));
    w.size = 2'($urandom_range(0, 2));
    w.data = $urandom();
    nb = 32'd1 << w.size;
    off = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 255)
                                        : RAM_BYTES - 64 + $urandom_range(0, 63);
    pick = $urandom_range(0, 99);
    if (pick >= 30 && pick < 55 && stored_spans.size() != 0) begin
      sp = stored_spans[$urandom_range(0, stored_spans.size() - 1)];
      w.cmd  = CMD_READ;
      w.size = SZ_BYTE;
      w.addr = cfg_ram_base + sp.off;
      found = 1'b0;
      for (int t = 0; t < 4 && !found; t++) begin
        s = 2'($urandom_range(0, sp.size));
        a = cfg_ram_base + sp.off + $urandom_range(0, (1 << sp.size) - (1 << s));
        if ((a & ((32'd1 << s) - 32'd1)) == 32'd0) begin
          w.size = s;
          w.addr = a;
          found = 1'b1;
        end
      end
    end else if (pick < 55) begin
      w.cmd  = CMD_WRITE;
      w.addr = (cfg_ram_base + off) & ~(nb - 32'd1);
    end else if (pick < 67) begin
      w.cmd  = CMD_WRITE;
      w.size = 2'($urandom_range(0, 3));
      w.addr = cfg_con_base + 4 * $urandom_range(0, 2);
    end else if (pick < 72) begin
      w.size = 2'($urandom_range(0, 3));
      w.addr = cfg_con_base + $urandom_range(0, 11);
    end else if (pick < 75) begin
      w.cmd  = CMD_READ;
      w.size = 2'($urandom_range(0, 3));
      w.addr = cfg_con_base + $urandom_range(0, 11);
    end else if (pick < 80) begin
      w.size = 2'($urandom_range(1, 2));
      nb = 32'd1 << w.size;
      w.addr = ((cfg_ram_base + off) & ~(nb - 32'd1)) | $urandom_range(1, nb - 1);
    end else if (pick < 84) begin
      w.size = SZ_BAD;
      w.addr = cfg_ram_base + off;
    end else if (pick < 89) begin
      w.size = 2'($urandom_range(0, 3));
      w.addr = $urandom();
    end else if (pick < 93) begin
      w.size = 2'($urandom_range(1, 2));
      nb = 32'd1 << w.size;
      w.addr = cfg_ram_base + RAM_BYTES - $urandom_range(1, nb - 1);
    end else begin
      w.size = 2'($urandom_range(0, 3));
      w.addr = $urandom();
    end
    w.hold = ($urandom_range(0, 99) == 0);
    return w;
  endfunction

  // Word driver: presents queued words, predicting each one as it is taken.
  always @(posedge clk) begin : drive_words
    bit taken, go;
    taken = start && !busy;
    if (taken) expected_replies.push_back(bus_access_reply(active_word));
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      go = pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct;
      if (go && pending_words[0].hold && (taken || expected_replies.size() != 0)) go = 1'b0;
      if (go) begin
        active_word = pending_words.pop_front();
        start          <= 1'b1;
        in_command     <= active_word.cmd;
        in_access_size <= active_word.size;
        in_address     <= active_word.addr;
        in_write_data  <= active_word.data;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_replies
    bus_reply_t e;
    if (rst_n && out_valid) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected reply: read_data %h status %0d", out_read_data, out_status);
        mismatches++;
      end else begin
        e = expected_replies.pop_front();
        if (out_read_data !== e.rdata) begin
          $error("read_data: expected %h, got %h", e.rdata, out_read_data);
          mismatches++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          mismatches++;
        end
        if (out_console_valid !== e.cvalid) begin
          $error("console_valid: expected %0d, got %0d", e.cvalid, out_console_valid);
          mismatches++;
        end
        if (out_console_kind !== e.ckind) begin
          $error("console_kind: expected %0d, got %0d", e.ckind, out_console_kind);
          mismatches++;
        end
        if (out_console_value !== e.cvalue) begin
          $error("console_value: expected %h, got %h", e.cvalue, out_console_value);
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_RAM_BASE) cfg_ram_base = value;
    else cfg_con_base = value;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || start || busy || expected_replies.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int idle_pct);
    bus_word_t w;
    sender_idle_pct = idle_pct;
    for (int k = 0; k < count; k++) begin
      w = random_word();
      if (k == 10) w.hold = 1'b1;
      post_word(w);
    end
    wait_idle();
  endtask

  initial begin : run_test
    logic [31:0] base;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    sender_idle_pct = 10;

    post_word(bus_word(CMD_WRITE, SZ_BYTE, CON_BASE_RST + CON_OFF_CHAR, 32'hFFFF_FF41));
    post_word(bus_word(CMD_WRITE, SZ_WORD, CON_BASE_RST + CON_OFF_DEC, 32'h8000_0000));
    post_word(bus_word(CMD_WRITE, SZ_BAD, CON_BASE_RST + CON_OFF_HEX, 32'hFFFF_FFFF));
    post_word(bus_word(CMD_WRITE, SZ_HALF, CON_BASE_RST + 1, 32'h1234_5678));
    post_word(bus_word(CMD_READ, SZ_WORD, CON_BASE_RST, 32'h0));
    post_word(bus_word(CMD_READ, SZ_BAD, CON_BASE_RST + CON_OFF_HEX, 32'h0));
    post_word(bus_word(CMD_WRITE, SZ_WORD, RAM_BASE_RST, 32'hDEAD_BEEF));
    post_word(bus_word(CMD_READ, SZ_WORD, RAM_BASE_RST, 32'h0));
    post_word(bus_word(CMD_READ, SZ_BYTE, RAM_BASE_RST + 3, 32'h0));
    post_word(bus_word(CMD_READ, SZ_HALF, RAM_BASE_RST + 2, 32'h0));
    post_word(bus_word(CMD_WRITE, SZ_BYTE, RAM_BASE_RST + 1, 32'hFFFF_FF00));
    post_word(bus_word(CMD_READ, SZ_WORD, RAM_BASE_RST, 32'h0));
    post_word(bus_word(CMD_WRITE, SZ_WORD, RAM_BASE_RST + RAM_BYTES - 4, 32'h0));
    post_word(bus_word(CMD_WRITE, SZ_HALF, RAM_BASE_RST + RAM_BYTES - 2, 32'h0000_FFFF));
    post_word(bus_word(CMD_READ, SZ_WORD, RAM_BASE_RST + RAM_BYTES - 4, 32'h0));
    post_word(bus_word(CMD_READ, SZ_BYTE, RAM_BASE_RST + RAM_BYTES - 1, 32'h0));
    post_word(bus_word(CMD_WRITE, SZ_HALF, RAM_BASE_RST + 1, 32'hFFFF_FFFF));
    post_word(bus_word(CMD_READ, SZ_WORD, RAM_BASE_RST + 2, 32'h0));
    post_word(bus_word(CMD_READ, SZ_BAD, RAM_BASE_RST + 4, 32'h0));
    post_word(bus_word(CMD_READ, SZ_BAD, RAM_BASE_RST + 5, 32'h0));
    post_word(bus_word(CMD_READ, SZ_WORD, 32'h0000_0000, 32'h0));
    post_word(bus_word(CMD_WRITE, SZ_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    post_word(bus_word(CMD_READ, SZ_BYTE, RAM_BASE_RST + RAM_BYTES, 32'h0));
    post_word(bus_word(CMD_READ, SZ_BYTE, RAM_BASE_RST - 1, 32'h0));
    post_word(bus_word(CMD_WRITE, SZ_BYTE, CON_BASE_RST + CON_SPAN, 32'h0000_0055));
    run_phase(150, 10);

    write_reg(CFG_RAM_BASE, 32'h0000_0000);
    write_reg(CFG_CON_BASE, 32'h0000_0000);
    run_phase(150, 50);

    write_reg(CFG_RAM_BASE, 32'hFFFF_FFFF);
    write_reg(CFG_CON_BASE, 32'hFFFF_FFFF);
    run_phase(150, 0);

    base = ($urandom() & 32'hFFFF_FFFC) | 32'd2;
    write_reg(CFG_RAM_BASE, base);
    write_reg(CFG_CON_BASE, $urandom());
    run_phase(150, 0);

    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("tb_system_bus_memory_console: PASS");
    else $display("tb_system_bus_memory_console: FAIL");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb_system_bus_memory_console: FAIL");
    $finish;
  end

endmodule
